### sv/rx_aggregate_deframer_top_defines.svh
// Assertion macros shared by the checker of the receive deframer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RX_AGGREGATE_DEFRAMER_TOP_DEFINES_SVH
`define RX_AGGREGATE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RAD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define RAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication that also covers the reset cycles.
`define RAD_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### sv/rad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rad_pkg;

  localparam int unsigned HEADER_BYTES_DEF     = 4;
  localparam int unsigned TRAILER_BYTES_DEF    = 4;
  localparam int unsigned DESCRIPTOR_BYTES_DEF = 24;
  localparam int unsigned BUFFER_BYTES_DEF     = 32768;

  // Segment lengths must be a multiple of four.
  localparam logic [15:0] ALIGN_MASK = 16'h0003;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [1:0] KIND_DESC    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STOP    = 2'd2;

  localparam logic [2:0] STOP_CLEAN_END   = 3'd0;
  localparam logic [2:0] STOP_ZERO_LENGTH = 3'd1;
  localparam logic [2:0] STOP_OVERRUN     = 3'd2;
  localparam logic [2:0] STOP_MISALIGNED  = 3'd3;
  localparam logic [2:0] STOP_SHORT       = 3'd4;
  localparam logic [2:0] STOP_FAILED      = 3'd5;
  localparam logic [2:0] STOP_DISABLED    = 3'd6;

  typedef struct packed {
    logic        op;
    logic [15:0] buffer_length;
    logic        transfer_failed;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       segment_last;
    logic [2:0] stop_reason;
  } out_item_t;

endpackage
`default_nettype wire

### sv/rad_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Receive side: buffer start items and buffer bytes.
interface rad_rx_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] buffer_length;
  logic        transfer_failed;
  logic [7:0]  data_byte;

  modport source (output valid, output op, output buffer_length,
                  output transfer_failed, output data_byte, input ready);
  modport sink (input valid, input op, input buffer_length,
                input transfer_failed, input data_byte, output ready);
endinterface

// Result side: descriptor bytes, payload bytes and stop reports.
interface rad_seg_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       segment_last;
  logic [2:0] stop_reason;

  modport source (output valid, output kind, output out_byte,
                  output segment_last, output stop_reason, input ready);
  modport sink (input valid, input kind, input out_byte,
                input segment_last, input stop_reason, output ready);
endinterface
`default_nettype wire

### sv/rad_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// Input register. Holds one accepted transaction until the parser consumes it.
module rad_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  rad_rx_if.sink            rx,
  input  wire logic         advance,
  output rad_pkg::in_item_t item,
  output logic              item_valid
);

  assign rx.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx.ready) begin
      item_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.op              <= rx.op;
      item.buffer_length   <= rx.buffer_length;
      item.transfer_failed <= rx.transfer_failed;
      item.data_byte       <= rx.data_byte;
    end
  end

endmodule
`default_nettype wire

### sv/rad_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Segment parser. Holds the buffer and segment state and turns the item in the
// input register into at most one result in the same cycle.
module rad_parser #(
  parameter int unsigned HEADER_BYTES     = rad_pkg::HEADER_BYTES_DEF,
  parameter int unsigned TRAILER_BYTES    = rad_pkg::TRAILER_BYTES_DEF,
  parameter int unsigned DESCRIPTOR_BYTES = rad_pkg::DESCRIPTOR_BYTES_DEF,
  parameter int unsigned BUFFER_BYTES     = rad_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire rad_pkg::in_item_t item,
  input  wire logic              advance,
  output rad_pkg::out_item_t     res,
  output logic                   res_valid
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_TRAILER
  } phase_t;

  localparam logic [16:0] MinSegment = 17'(HEADER_BYTES + DESCRIPTOR_BYTES + TRAILER_BYTES);
  localparam logic [16:0] HeaderLen  = 17'(HEADER_BYTES);
  localparam logic [16:0] TrailerLen = 17'(TRAILER_BYTES);
  localparam logic [15:0] DescLen    = 16'(DESCRIPTOR_BYTES);
  localparam logic [15:0] BufferCap  = 16'(BUFFER_BYTES);
  localparam logic [17:0] FrameExtra = 18'(HEADER_BYTES + TRAILER_BYTES);

  logic        rx_enabled;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] segment_position, segment_position_next;
  logic [15:0] segment_length, segment_length_next;
  logic [7:0]  length_low_byte, length_low_byte_next;
  phase_t      parse_phase, parse_phase_next;
  logic        discarding, discarding_next;

  logic        do_stop;
  logic [2:0]  stop_code;
  logic [15:0] start_len;
  logic [15:0] hdr_len;
  logic [16:0] pos_inc;
  logic [15:0] remaining_dec;

  always_comb begin
    bytes_remaining_next  = bytes_remaining;
    segment_position_next = segment_position;
    segment_length_next   = segment_length;
    length_low_byte_next  = length_low_byte;
    parse_phase_next      = parse_phase;
    discarding_next       = discarding;
    do_stop               = 1'b0;
    stop_code             = rad_pkg::STOP_CLEAN_END;
    res_valid             = 1'b0;
    res                   = '0;

    start_len     = (item.buffer_length > BufferCap) ? BufferCap : item.buffer_length;
    hdr_len       = {item.data_byte, length_low_byte};
    pos_inc       = {1'b0, segment_position} + 17'd1;
    remaining_dec = bytes_remaining - 16'd1;

    if (item.op == rad_pkg::OP_START) begin
      bytes_remaining_next  = start_len;
      segment_position_next = '0;
      segment_length_next   = '0;
      length_low_byte_next  = '0;
      if (item.transfer_failed) begin
        do_stop   = 1'b1;
        stop_code = rad_pkg::STOP_FAILED;
      end else if (!rx_enabled) begin
        do_stop   = 1'b1;
        stop_code = rad_pkg::STOP_DISABLED;
      end else if ({1'b0, start_len} < MinSegment) begin
        do_stop   = 1'b1;
        stop_code = rad_pkg::STOP_CLEAN_END;
      end else begin
        discarding_next  = 1'b0;
        parse_phase_next = PH_HEADER;
      end
    end else if (bytes_remaining != 16'd0) begin
      bytes_remaining_next = remaining_dec;
      if (!discarding) begin
        case (parse_phase)
          PH_HEADER: begin
            if (segment_position == 16'd0 && {1'b0, bytes_remaining} < MinSegment) begin
              do_stop   = 1'b1;
              stop_code = rad_pkg::STOP_CLEAN_END;
            end else if (segment_position == 16'd1) begin
              // The length field is complete: check it before going on.
              segment_length_next = hdr_len;
              if (hdr_len == 16'd0) begin
                do_stop   = 1'b1;
                stop_code = rad_pkg::STOP_ZERO_LENGTH;
              end else if ({2'b0, hdr_len} + FrameExtra > {2'b0, bytes_remaining} + 18'd1) begin
                do_stop   = 1'b1;
                stop_code = rad_pkg::STOP_OVERRUN;
              end else if ((hdr_len & rad_pkg::ALIGN_MASK) != 16'd0) begin
                do_stop   = 1'b1;
                stop_code = rad_pkg::STOP_MISALIGNED;
              end else if (hdr_len < DescLen) begin
                do_stop   = 1'b1;
                stop_code = rad_pkg::STOP_SHORT;
              end
            end
            if (segment_position == 16'd0 && !do_stop) begin
              length_low_byte_next = item.data_byte;
            end
            if (!do_stop) begin
              if (pos_inc >= HeaderLen) begin
                parse_phase_next      = PH_BODY;
                segment_position_next = '0;
              end else begin
                segment_position_next = pos_inc[15:0];
              end
            end
          end
          PH_BODY: begin
            res_valid        = 1'b1;
            res.kind         = (segment_position < DescLen) ? rad_pkg::KIND_DESC
                                                            : rad_pkg::KIND_PAYLOAD;
            res.out_byte     = item.data_byte;
            res.segment_last = (pos_inc == {1'b0, segment_length});
            if (pos_inc >= {1'b0, segment_length}) begin
              segment_position_next = '0;
              parse_phase_next      = (TRAILER_BYTES > 0) ? PH_TRAILER : PH_HEADER;
            end else begin
              segment_position_next = pos_inc[15:0];
            end
          end
          PH_TRAILER: begin
            if (pos_inc >= TrailerLen) begin
              segment_position_next = '0;
              parse_phase_next      = PH_HEADER;
              if ({1'b0, remaining_dec} < MinSegment) begin
                do_stop   = 1'b1;
                stop_code = rad_pkg::STOP_CLEAN_END;
              end
            end else begin
              segment_position_next = pos_inc[15:0];
            end
          end
          default: begin
            // Idle: bytes are dropped.
          end
        endcase
      end
    end

    if (do_stop) begin
      res_valid             = 1'b1;
      res.kind              = rad_pkg::KIND_STOP;
      res.out_byte          = '0;
      res.segment_last      = 1'b0;
      res.stop_reason       = stop_code;
      discarding_next       = 1'b1;
      parse_phase_next      = PH_IDLE;
      segment_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enabled       <= 1'b0;
      bytes_remaining  <= '0;
      segment_position <= '0;
      segment_length   <= '0;
      length_low_byte  <= '0;
      parse_phase      <= PH_IDLE;
      discarding       <= 1'b1;
    end else begin
      if (cfg_we) begin
        rx_enabled <= cfg_wdata;
      end
      if (advance) begin
        bytes_remaining  <= bytes_remaining_next;
        segment_position <= segment_position_next;
        segment_length   <= segment_length_next;
        length_low_byte  <= length_low_byte_next;
        parse_phase      <= parse_phase_next;
        discarding       <= discarding_next;
      end
    end
  end

endmodule
`default_nettype wire

### sv/rad_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// Result register. Loads whenever it is empty or its content is being taken.
module rad_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rad_pkg::out_item_t res,
  input  wire logic               res_valid,
  input  wire logic               item_valid,
  output logic                    advance,
  rad_seg_if.source               seg
);

  logic out_free;

  assign out_free = !seg.valid || seg.ready;
  assign advance  = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (out_free) begin
      seg.valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      seg.kind         <= res.kind;
      seg.out_byte     <= res.out_byte;
      seg.segment_last <= res.segment_last;
      seg.stop_reason  <= res.stop_reason;
    end
  end

endmodule
`default_nettype wire

### sv/rx_aggregate_deframer_top.sv
// Receive aggregate deframer. A start transaction announces a transfer buffer
// (length, failure flag) and the buffer bytes follow, one per transaction. The
// block parses length-prefixed segments out of the buffer and returns their
// descriptor and payload bytes, marking the last byte of each segment, plus a
// stop report when parsing of a buffer ends. It takes one transaction every
// clock cycle while the result side is not stalled; a result is registered in
// the result register after its input leaves the input register, with the
// combinational segment parser between them. Backpressure on the result side
// stalls the input within the same cycle. There is no clearing pass after
// reset; the input is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module rx_aggregate_deframer_top #(
  parameter int unsigned HEADER_BYTES     = rad_pkg::HEADER_BYTES_DEF,
  parameter int unsigned TRAILER_BYTES    = rad_pkg::TRAILER_BYTES_DEF,
  parameter int unsigned DESCRIPTOR_BYTES = rad_pkg::DESCRIPTOR_BYTES_DEF,
  parameter int unsigned BUFFER_BYTES     = rad_pkg::BUFFER_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  // Configuration: the single rx_enabled register.
  input wire logic cfg_we,
  input wire logic cfg_wdata,
  rad_rx_if.sink   rx,
  rad_seg_if.source seg
);

  // The input register holds the accepted transaction for the parser.
  rad_pkg::in_item_t  item;
  logic               item_valid;
  // The parser result feeds the result register.
  rad_pkg::out_item_t res;
  logic               res_valid;
  // High when the held transaction is consumed and the parser state updates.
  logic               advance;

  rad_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  rad_parser #(
    .HEADER_BYTES     (HEADER_BYTES),
    .TRAILER_BYTES    (TRAILER_BYTES),
    .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES),
    .BUFFER_BYTES     (BUFFER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .advance   (advance),
    .res       (res),
    .res_valid (res_valid)
  );

  // Every consumed transaction leaves the input register, whether or not it
  // produced a result; stop reports and bytes share the one result register.
  rad_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .res_valid  (res_valid),
    .item_valid (item_valid),
    .advance    (advance),
    .seg        (seg)
  );

endmodule
`default_nettype wire

### sv/rad_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rx_aggregate_deframer_top_defines.svh"
// Port-level checks for the receive deframer.
module rad_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       seg_valid,
  input wire logic       seg_ready,
  input wire logic [1:0] seg_kind,
  input wire logic [7:0] seg_out_byte,
  input wire logic       seg_segment_last,
  input wire logic [2:0] seg_stop_reason
);

  logic stop_shown;
  logic data_shown;

  assign stop_shown = seg_valid && seg_kind == rad_pkg::KIND_STOP;
  assign data_shown = seg_valid && seg_kind != rad_pkg::KIND_STOP;

  `RAD_ASSERT_SAME(stop_fields_clear, stop_shown, seg_out_byte == 8'd0 && !seg_segment_last)
  `RAD_ASSERT_SAME(data_reason_clear, data_shown, seg_stop_reason == rad_pkg::STOP_CLEAN_END)
  `RAD_ASSERT_SAME(stop_reason_known, stop_shown, seg_stop_reason <= rad_pkg::STOP_DISABLED)
  `RAD_ASSERT_NEXT(stall_holds, seg_valid && !seg_ready, seg_valid && $stable(seg_out_byte))
  `RAD_ASSERT_NEXT_ALWAYS(reset_empties, rst, !seg_valid)

endmodule

bind rx_aggregate_deframer_top rad_port_checks u_rad_port_checks (
  .clk              (clk),
  .rst              (rst),
  .seg_valid        (seg.valid),
  .seg_ready        (seg.ready),
  .seg_kind         (seg.kind),
  .seg_out_byte     (seg.out_byte),
  .seg_segment_last (seg.segment_last),
  .seg_stop_reason  (seg.stop_reason)
);
`default_nettype wire
